// File: sv/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared widths, constants, pipeline payload types and the divider step.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

  localparam int CH_W            = 8;
  localparam int HUE_W           = 9;
  localparam int DVD_W           = 2 * CH_W;
  localparam int LANES           = 2;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = CH_W / STEPS_PER_STAGE;

  localparam logic [0:0] LANE_SAT = 1'b0;
  localparam logic [0:0] LANE_HUE = 1'b1;

  localparam logic [CH_W-1:0]  SAT_FULL   = 8'd255;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 9'd60;
  localparam logic [HUE_W-1:0] HUE_RED    = 9'd0;
  localparam logic [HUE_W-1:0] HUE_GREEN  = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BLUE   = 9'd240;
  localparam logic [HUE_W-1:0] HUE_WRAP   = 9'd360;

  typedef struct packed {
    logic [CH_W-1:0] rem;
    logic [CH_W-1:0] low;
    logic [CH_W-1:0] dvsr;
    logic [CH_W-1:0] quo;
  } div_lane_t;

  typedef div_lane_t [LANES-1:0] div_pair_t;

  typedef struct packed {
    logic [HUE_W-1:0] base;
    logic             neg;
    logic             zd;
    logic [CH_W-1:0]  val;
  } pix_side_t;

  function automatic div_lane_t div_step(input div_lane_t l);
    logic [CH_W:0] trial;
    logic [CH_W:0] diff;
    div_lane_t     r;
    trial = {l.rem, l.low[CH_W-1]};
    diff  = trial - {1'b0, l.dvsr};
    r     = l;
    r.low = {l.low[CH_W-2:0], 1'b0};
    if (trial >= {1'b0, l.dvsr}) begin
      r.rem = diff[CH_W-1:0];
      r.quo = {l.quo[CH_W-2:0], 1'b1};
    end else begin
      r.rem = trial[CH_W-1:0];
      r.quo = {l.quo[CH_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/rgbhsv_prep.sv
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds the largest and smallest channel, the hue sector and the two
// dividends, and registers them as the first pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_prep
  import rgbhsv_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [CH_W-1:0] red_i,
  input  wire logic [CH_W-1:0] green_i,
  input  wire logic [CH_W-1:0] blue_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output div_pair_t            out_lanes_o,
  output pix_side_t            out_side_o
);

  logic             valid_q;
  logic             en;
  logic [CH_W-1:0]  mx;
  logic [CH_W-1:0]  mn;
  logic [CH_W-1:0]  delta;
  logic [CH_W-1:0]  absd;
  logic             neg;
  logic [HUE_W-1:0] base;
  logic [DVD_W-1:0] hue_num;
  logic [DVD_W-1:0] sat_num;
  div_pair_t        lanes_d;
  div_pair_t        lanes_q;
  pix_side_t        side_d;
  pix_side_t        side_q;

  always_comb begin
    mn = red_i;
    if (green_i < mn) begin
      mn = green_i;
    end
    if (blue_i < mn) begin
      mn = blue_i;
    end

    priority if ((red_i >= green_i) && (red_i >= blue_i)) begin
      mx   = red_i;
      neg  = green_i < blue_i;
      absd = neg ? (blue_i - green_i) : (green_i - blue_i);
      base = neg ? HUE_WRAP : HUE_RED;
    end else if (green_i >= blue_i) begin
      mx   = green_i;
      neg  = blue_i < red_i;
      absd = neg ? (red_i - blue_i) : (blue_i - red_i);
      base = HUE_GREEN;
    end else begin
      mx   = blue_i;
      neg  = red_i < green_i;
      absd = neg ? (green_i - red_i) : (red_i - green_i);
      base = HUE_BLUE;
    end

    delta   = mx - mn;
    hue_num = DVD_W'(absd) * DVD_W'(HUE_SECTOR);
    sat_num = DVD_W'(delta) * DVD_W'(SAT_FULL);

    lanes_d[LANE_SAT] = '{rem: sat_num[DVD_W-1:CH_W], low: sat_num[CH_W-1:0],
                          dvsr: mx, quo: '0};
    lanes_d[LANE_HUE] = '{rem: hue_num[DVD_W-1:CH_W], low: hue_num[CH_W-1:0],
                          dvsr: delta, quo: '0};
    side_d = '{base: base, neg: neg, zd: (delta == '0), val: mx};
  end

  assign en = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      lanes_q <= lanes_d;
      side_q  <= side_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = valid_q;
  assign out_lanes_o = lanes_q;
  assign out_side_o  = side_q;

endmodule

`default_nettype wire

// File: sv/rgbhsv_div_pipe.sv
// ----------------------------------------------------------------------------
// RGB to HSV divider pipeline
// Two restoring dividers in lockstep, a fixed number of quotient bits per
// stage, with the pixel sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_div_pipe
  import rgbhsv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire div_pair_t  in_lanes_i,
  input  wire pix_side_t  in_side_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output div_pair_t       out_lanes_o,
  output pix_side_t       out_side_o
);

  logic [DIV_STAGES-1:0] valid_q;
  logic [DIV_STAGES-1:0] en;
  div_pair_t             lanes_q [DIV_STAGES];
  pix_side_t             side_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic      stg_valid;
    logic      stg_ready;
    div_pair_t stg_lanes;
    pix_side_t stg_side;
    div_pair_t stepped;

    if (s == 0) begin : g_first
      assign stg_valid = in_valid_i;
      assign stg_lanes = in_lanes_i;
      assign stg_side  = in_side_i;
    end else begin : g_mid
      assign stg_valid = valid_q[s-1];
      assign stg_lanes = lanes_q[s-1];
      assign stg_side  = side_q[s-1];
    end

    if (s == DIV_STAGES - 1) begin : g_last
      assign stg_ready = out_ready_i;
    end else begin : g_next
      assign stg_ready = en[s+1];
    end

    assign en[s] = !valid_q[s] || stg_ready;

    always_comb begin
      stepped = stg_lanes;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        for (int l = 0; l < LANES; l++) begin
          stepped[l] = div_step(stepped[l]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en[s]) begin
        valid_q[s] <= stg_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && stg_valid) begin
        lanes_q[s] <= stepped;
        side_q[s]  <= stg_side;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[DIV_STAGES-1];
  assign out_lanes_o = lanes_q[DIV_STAGES-1];
  assign out_side_o  = side_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: sv/rgbhsv_post.sv
// ----------------------------------------------------------------------------
// RGB to HSV output stage
// Turns the quotients into hue, saturation and value and holds the result
// in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_post
  import rgbhsv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire div_pair_t   in_lanes_i,
  input  wire pix_side_t   in_side_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [HUE_W-1:0] hue_deg_o,
  output logic [CH_W-1:0]  sat_level_o,
  output logic [CH_W-1:0]  val_level_o
);

  logic             valid_q;
  logic             en;
  logic [HUE_W-1:0] quo9;
  logic [HUE_W-1:0] hue_d;
  logic [HUE_W-1:0] hue_q;
  logic [CH_W-1:0]  sat_d;
  logic [CH_W-1:0]  sat_q;
  logic [CH_W-1:0]  val_q;
  logic             rem_nz;

  always_comb begin
    quo9   = HUE_W'(in_lanes_i[LANE_HUE].quo);
    rem_nz = in_lanes_i[LANE_HUE].rem != '0;
    if (in_side_i.zd) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = in_side_i.neg ? (in_side_i.base - quo9 - HUE_W'(rem_nz))
                            : (in_side_i.base + quo9);
      sat_d = in_lanes_i[LANE_SAT].quo;
    end
  end

  assign en = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= in_side_i.val;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = valid_q;
  assign hue_deg_o   = hue_q;
  assign sat_level_o = sat_q;
  assign val_level_o = val_q;

  a_hue_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_side_i.zd) |->
      (HUE_W'(in_lanes_i[LANE_HUE].quo) <= HUE_SECTOR))
    else $error("hue quotient above one sector");

  a_hue_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_side_i.zd) |->
      (in_lanes_i[LANE_HUE].rem < in_lanes_i[LANE_HUE].dvsr))
    else $error("hue remainder not below divisor");

  a_sat_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_side_i.zd) |->
      (in_lanes_i[LANE_SAT].rem < in_lanes_i[LANE_SAT].dvsr))
    else $error("saturation remainder not below divisor");

endmodule

`default_nettype wire

// File: sv/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts one 8-bit RGB pixel per cycle, unless stalled, to hue in degrees,
// saturation and value, using exact integer quotients.
//
//   Channel   Signals                                   Direction
//   input     in_valid_i, in_ready_o, red/green/blue_i  request in
//   output    out_valid_o, out_ready_i, hue/sat/val_o   request out
//
// One request enters per cycle unless stalled; stages are one front stage,
// four divider stages of two quotient bits each, and the output register.
// Reset clears all stage valid bits; no data registers are reset.
// A stall at the output fills empty stages first and then holds each
// stage in place, so no request is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_pixel
  import rgbhsv_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [CH_W-1:0]  red_i,
  input  wire logic [CH_W-1:0]  green_i,
  input  wire logic [CH_W-1:0]  blue_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [HUE_W-1:0]      hue_deg_o,
  output logic [CH_W-1:0]       sat_level_o,
  output logic [CH_W-1:0]       val_level_o
);

  logic      prep_valid;
  logic      div_ready;
  div_pair_t prep_lanes;
  pix_side_t prep_side;
  logic      div_valid;
  logic      post_ready;
  div_pair_t div_lanes;
  pix_side_t div_side;

  rgbhsv_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (prep_valid),
    .out_ready_i (div_ready),
    .out_lanes_o (prep_lanes),
    .out_side_o  (prep_side)
  );

  rgbhsv_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (div_ready),
    .in_lanes_i  (prep_lanes),
    .in_side_i   (prep_side),
    .out_valid_o (div_valid),
    .out_ready_i (post_ready),
    .out_lanes_o (div_lanes),
    .out_side_o  (div_side)
  );

  rgbhsv_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (post_ready),
    .in_lanes_i  (div_lanes),
    .in_side_i   (div_side),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hue_deg_o   (hue_deg_o),
    .sat_level_o (sat_level_o),
    .val_level_o (val_level_o)
  );

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_deg_o < HUE_WRAP))
    else $error("hue out of range");

  a_black_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (val_level_o == '0)) |->
      ((sat_level_o == '0) && (hue_deg_o == '0)))
    else $error("black pixel with nonzero hue or saturation");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output side is free");

endmodule

`default_nettype wire

// File: verif/tb_rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter testbench
// Sends pixel requests through the converter while both sides stall at
// random, including one long output stall that backs the pipeline up.
// Hue, saturation and value are known or predicted for every accepted request and
// checked in order against the requests that come out.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbhsv_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 4;
  localparam int RANDOM_PER_PHASE = 126;
  localparam int LONG_STALL       = 200;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int MAX_REPORTS      = 10;
  localparam int NUM_PHASES       = 3;
  localparam int NUM_ROWS         = 24;
  localparam int EXP_DEPTH        = 512;

  localparam int SEND_IDLE [NUM_PHASES] = '{26, 76, 0};
  localparam int RECV_IDLE [NUM_PHASES] = '{76, 26, 0};

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } hsv_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    bit              known;
    hsv_t            want;
  } pix_row_t;

  // Rows marked known carry their result; the rest are predicted.
  localparam pix_row_t PIX_TABLE [NUM_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   8'd0,   8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{9'd0,   8'd0,   8'd128}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{9'd0,   8'd0,   8'd1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, 8'd255, 8'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, 8'd255, 8'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{9'd60,  8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{9'd180, 8'd255, 8'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{9'd300, 8'd255, 8'd255}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd1}},
    '{8'd0,   8'd1,   8'd0,   1'b1, '{9'd120, 8'd255, 8'd1}},
    '{8'd0,   8'd0,   8'd1,   1'b1, '{9'd240, 8'd255, 8'd1}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd255, 8'd1,   8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd255, 1'b0, '0},
    '{8'd1,   8'd0,   8'd255, 1'b0, '0},
    '{8'd1,   8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd1,   1'b0, '0},
    '{8'd255, 8'd254, 8'd254, 1'b0, '0},
    '{8'd254, 8'd255, 8'd254, 1'b0, '0},
    '{8'd254, 8'd254, 8'd255, 1'b0, '0},
    '{8'd170, 8'd85,  8'd0,   1'b0, '0},
    '{8'd255, 8'd128, 8'd128, 1'b0, '0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic             out_valid;
  logic             out_ready;
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  sat;
  logic [CH_W-1:0]  val;

  hsv_t exp_fifo [EXP_DEPTH];
  int   exp_wr = 0;
  int   exp_rd = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   long_stall_pending = 1'b0;
  int   mismatches = 0;
  int   cycle_count = 0;

  rgb_to_hsv_pixel dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .hue_deg_o   (hue),
    .sat_level_o (sat),
    .val_level_o (val)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic hsv_t hsv_of(input logic [CH_W-1:0] r, g, b);
    int   hi;
    int   lo;
    int   span;
    int   num;
    hsv_t res;
    hi = (int'(r) > int'(g)) ? int'(r) : int'(g);
    if (int'(b) > hi) hi = int'(b);
    lo = (int'(r) < int'(g)) ? int'(r) : int'(g);
    if (int'(b) < lo) lo = int'(b);
    span = hi - lo;
    res = '0;
    res.val = CH_W'(hi);
    if (hi != 0) begin
      res.sat = CH_W'((span * 255) / hi);
      if (span != 0) begin
        if (int'(r) == hi) begin
          num = 60 * (int'(g) - int'(b));
        end else if (int'(g) == hi) begin
          num = 120 * span + 60 * (int'(b) - int'(r));
        end else begin
          num = 240 * span + 60 * (int'(r) - int'(g));
        end
        if (num < 0) num = num + 360 * span;
        res.hue = HUE_W'(num / span);
      end
    end
    return res;
  endfunction

  function automatic logic [CH_W-1:0] edge_value();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Mix of uniform pixels with corner values, greys and ties for the maximum.
  task automatic pick_pixel(output logic [CH_W-1:0] r, g, b);
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] lo;
    hi = 8'($urandom);
    lo = 8'($urandom_range(hi));
    case ($urandom_range(9))
      0, 1: begin
        r = edge_value();
        g = edge_value();
        b = edge_value();
      end
      2: begin
        r = hi;
        g = hi;
        b = hi;
      end
      3: begin
        case ($urandom_range(2))
          0: begin r = hi; g = hi; b = lo; end
          1: begin r = hi; g = lo; b = hi; end
          default: begin r = lo; g = hi; b = hi; end
        endcase
      end
      default: begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end
    endcase
  endtask

  task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input bit known,
                            input hsv_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_fifo[exp_wr % EXP_DEPTH] = known ? typed : hsv_of(r, g, b);
    exp_wr = exp_wr + 1;
    @(negedge clk);
  endtask

  initial begin : receiver
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_pending) begin
        hold = LONG_STALL;
        long_stall_pending = 1'b0;
      end
      if (hold > 0) begin
        hold = hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    hsv_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_rd == exp_wr) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected request out: hue %0d sat %0d val %0d", hue, sat, val);
        end
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd = exp_rd + 1;
        if (hue !== want.hue || sat !== want.sat || val !== want.val) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected hue %0d sat %0d val %0d,",
                     want.hue, want.sat, want.val,
                     " got hue %0d sat %0d val %0d", hue, sat, val);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** rgb_to_hsv_pixel: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    red      = '0;
    green    = '0;
    blue     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_idle_pct = RECV_IDLE[p];
      if (p == 0) begin
        for (int i = 0; i < NUM_ROWS; i++) begin
          send_pixel(PIX_TABLE[i].r, PIX_TABLE[i].g, PIX_TABLE[i].b,
                     PIX_TABLE[i].known, PIX_TABLE[i].want);
        end
      end
      if (p == NUM_PHASES - 1) begin
        in_valid <= 1'b0;
        @(posedge clk);
        long_stall_pending = 1'b1;
        @(negedge clk);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        pick_pixel(r, g, b);
        send_pixel(r, g, b, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** rgb_to_hsv_pixel: PASSED **");
    end else begin
      $display("** rgb_to_hsv_pixel: FAILED **");
    end
    $finish;
  end

endmodule
